FILE: rtl/core/bpc_pkg.sv
// Shared constants, register codes and arithmetic helpers for the
// barometric pressure and temperature compensation block. No dependencies.
package bpc_pkg;

	localparam int unsigned DATA_W = 64;

	localparam logic [63:0] TEMP_OFFSET_FINE = 64'd128000;
	localparam logic [63:0] PRESS_FULL_SCALE = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE      = 64'd3125;
	localparam logic [31:0] TEMP_ROUND_ADD   = 32'd128;
	localparam logic [21:0] TENTHS_MAX       = 22'd32767;
	localparam logic [21:0] TENTHS_MIN_MAG   = 22'd32768;
	localparam logic [56:0] RECIP_TEN        = 57'h0CCCCCCCD;

	typedef enum logic [7:0] {
		REG_TEMP_COEF = 8'd0,
		REG_PRESS_LO  = 8'd1,
		REG_PRESS_HI  = 8'd2,
		REG_PRESS_C9  = 8'd3
	} cfg_reg_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx16w32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
		logic signed [63:0] s;
		s = $signed(v);
		return s >>> n;
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
		logic signed [31:0] s;
		s = $signed(v);
		return s >>> n;
	endfunction

endpackage

FILE: rtl/core/bpc_mul.sv
// Two-stage 64x64 multiplier lanes keeping the low 64 bits of each product,
// built from 32x32 partial products, with a side payload. Depends on nothing.
module bpc_mul #(
	parameter int LANES = 1,
	parameter int SW    = 1
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [LANES-1:0][63:0] a,
	input  logic [LANES-1:0][63:0] b,
	input  logic [SW-1:0]          side_in,
	output logic [LANES-1:0][63:0] p,
	output logic [SW-1:0]          side_out
);

	logic [LANES-1:0][63:0] ll_s1;
	logic [LANES-1:0][31:0] cross_s1;
	logic [SW-1:0]          side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				ll_s1[i]    <= 64'(a[i][31:0]) * 64'(b[i][31:0]);
				cross_s1[i] <= 32'(a[i][31:0] * b[i][63:32]) + 32'(a[i][63:32] * b[i][31:0]);
			end
			side_s1 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				p[i] <= ll_s1[i] + {cross_s1[i], 32'd0};
			end
			side_out <= side_s1;
		end
	end

endmodule

FILE: rtl/core/bpc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating
// toward zero, with a zero-divisor flag and side payload. Uses bpc_pkg.
module bpc_div
	import bpc_pkg::*;
#(
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [DATA_W-1:0] num,
	input  logic [DATA_W-1:0] den,
	input  logic [SW-1:0]     side_in,
	output logic [DATA_W-1:0] quo,
	output logic              dz,
	output logic [SW-1:0]     side_out
);

	localparam int W = DATA_W;

	logic [2*W:0]  w_q  [0:W];
	logic [W-1:0]  d_q  [0:W];
	logic          sg_q [0:W];
	logic          dz_q [0:W];
	logic [SW-1:0] sd_q [0:W];

	function automatic logic [2*W:0] div_step(input logic [2*W:0] w, input logic [W-1:0] d);
		logic [2*W:0] sh;
		sh = {w[2*W-1:0], 1'b0};
		if (sh[2*W:W] >= {1'b0, d}) begin
			sh[2*W:W] = sh[2*W:W] - {1'b0, d};
			sh[0]     = 1'b1;
		end
		return sh;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			w_q[0]  <= {{(W+1){1'b0}}, num[W-1] ? (~num + 1'b1) : num};
			d_q[0]  <= den[W-1] ? (~den + 1'b1) : den;
			sg_q[0] <= num[W-1] ^ den[W-1];
			dz_q[0] <= (den == '0);
			sd_q[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				w_q[k]  <= div_step(w_q[k-1], d_q[k-1]);
				d_q[k]  <= d_q[k-1];
				sg_q[k] <= sg_q[k-1];
				dz_q[k] <= dz_q[k-1];
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo      <= sg_q[W] ? (~w_q[W][W-1:0] + 1'b1) : w_q[W][W-1:0];
			dz       <= dz_q[W];
			side_out <= sd_q[W];
		end
	end

endmodule

FILE: rtl/core/baro_pressure_temp_compensation_top.sv
// Top level of the barometric compensation pipeline: configuration registers,
// temperature path and pressure path. Uses bpc_pkg, bpc_mul and bpc_div.
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    tdata: raw_pressure, raw_temperature
// m_*      out  m_tvalid / m_tready    tdata: pressure_pa, temperature_tenths
// cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat enters per cycle while the output is not stalled; its result passes through
// 86 register stages: 66 in the divider (64 quotient-bit stages plus entry and exit),
// 12 in the multipliers and 8 in the surrounding logic.
// Reset clears the valid chain and the calibration registers.
// A stalled output beat holds the whole pipeline; nothing is lost or repeated.
module baro_pressure_temp_compensation_top
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pressure_pa[31:0], temperature_tenths[47:32]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int LAT = 86;

	logic [47:0] tc_q;
	logic [63:0] pl_q;
	logic [63:0] ph_q;
	logic [15:0] p9_q;
	logic [LAT-1:0] vld_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign en        = !vld_q[LAT-1] || m_tready;
	assign s_tready  = en;
	assign m_tvalid  = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			pl_q <= '0;
			ph_q <= '0;
			p9_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEMP_COEF: tc_q <= cfg_data[47:0];
				REG_PRESS_LO:  pl_q <= cfg_data;
				REG_PRESS_HI:  ph_q <= cfg_data;
				REG_PRESS_C9:  p9_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	logic [19:0] raw_p, raw_t;
	logic [31:0] d1, d2, t2, t3, sq;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	assign raw_p = s_tdata[19:0];
	assign raw_t = s_tdata[39:20];
	assign t2    = sx16w32(tc_q[31:16]);
	assign t3    = sx16w32(tc_q[47:32]);
	assign d1    = {15'd0, raw_t[19:3]} - {15'd0, tc_q[15:0], 1'b0};
	assign d2    = {16'd0, raw_t[19:4]} - {16'd0, tc_q[15:0]};
	assign p1    = {48'd0, pl_q[15:0]};
	assign p2    = sx16(pl_q[31:16]);
	assign p3    = sx16(pl_q[47:32]);
	assign p4    = sx16(pl_q[63:48]);
	assign p5    = sx16(ph_q[15:0]);
	assign p6    = sx16(ph_q[31:16]);
	assign p7    = sx16(ph_q[47:32]);
	assign p8    = sx16(ph_q[63:48]);
	assign p9    = sx16(p9_q);

	// temperature front end
	logic [31:0] m1_s1, m2_s1, v1t_s2, m3_s2, fine_s3;
	logic [19:0] adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4;
	logic [23:0] t100_s4;
	logic [63:0] v1_s4;
	logic [31:0] t100_full;

	assign sq        = asr32(m2_s1, 12);
	assign t100_full = asr32(fine_s3 * 32'd5 + TEMP_ROUND_ADD, 8);

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1    <= d1 * t2;
			m2_s1    <= d2 * d2;
			adc_p_s1 <= raw_p;
			v1t_s2   <= asr32(m1_s1, 11);
			m3_s2    <= sq * t3;
			adc_p_s2 <= adc_p_s1;
			fine_s3  <= v1t_s2 + asr32(m3_s2, 14);
			adc_p_s3 <= adc_p_s2;
			t100_s4  <= t100_full[23:0];
			v1_s4    <= {{32{fine_s3[31]}}, fine_s3} - TEMP_OFFSET_FINE;
			adc_p_s4 <= adc_p_s3;
		end
	end

	// tenths: round half away from zero, divide by ten, saturate
	logic [24:0] tx, tmag;
	logic [56:0] tprod_s5;
	logic        tneg_s5;
	logic [21:0] tq;
	logic [15:0] t10_s6;

	assign tx   = {t100_s4[23], t100_s4} + (t100_s4[23] ? 25'h1FFFFFB : 25'd5);
	assign tmag = tx[24] ? (~tx + 1'b1) : tx;
	assign tq   = tprod_s5[56:35];

	always_ff @(posedge clk) begin
		if (en) begin
			tprod_s5 <= 57'(tmag) * RECIP_TEN;
			tneg_s5  <= t100_s4[23];
			if (!tneg_s5) begin
				t10_s6 <= (tq > TENTHS_MAX) ? TENTHS_MAX[15:0] : tq[15:0];
			end else begin
				t10_s6 <= (tq > TENTHS_MIN_MAG) ? 16'h8000 : (~tq[15:0] + 1'b1);
			end
		end
	end

	// pressure: v1*v1, v1*p5, v1*p2
	logic [2:0][63:0] m1_p;
	logic [19:0]      m1_side;

	bpc_mul #(.LANES(3), .SW(20)) u_mul_a (
		.clk(clk), .en(en),
		.a({v1_s4, v1_s4, v1_s4}),
		.b({p2, p5, v1_s4}),
		.side_in(adc_p_s4),
		.p(m1_p), .side_out(m1_side)
	);

	// A*p6, A*p3
	logic [1:0][63:0] m2_p;
	logic [163:0]     m2_side;

	bpc_mul #(.LANES(2), .SW(164)) u_mul_b (
		.clk(clk), .en(en),
		.a({m1_p[0], m1_p[0]}),
		.b({p3, p6}),
		.side_in({t10_s6, m1_side, m1_p[1], m1_p[2]}),
		.p(m2_p), .side_out(m2_side)
	);

	logic [63:0] v2_s9, x_s9;
	logic [19:0] adc_p_s9;
	logic [15:0] t10_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s9    <= m2_p[0] + {m2_side[110:64], 17'd0} + {p4[28:0], 35'd0};
			x_s9     <= 64'h0000_8000_0000_0000 + asr64(m2_p[1], 8) +
				{m2_side[51:0], 12'd0};
			adc_p_s9 <= m2_side[147:128];
			t10_s9   <= m2_side[163:148];
		end
	end

	logic [0:0][63:0] m3_p;
	logic [99:0]      m3_side;

	bpc_mul #(.LANES(1), .SW(100)) u_mul_c (
		.clk(clk), .en(en),
		.a(x_s9), .b(p1),
		.side_in({t10_s9, adc_p_s9, v2_s9}),
		.p(m3_p), .side_out(m3_side)
	);

	logic [63:0] den_s12, num_s12;
	logic [15:0] t10_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s12 <= asr64(m3_p[0], 33);
			num_s12 <= ((PRESS_FULL_SCALE - {44'd0, m3_side[83:64]}) << 31) - m3_side[63:0];
			t10_s12 <= m3_side[99:84];
		end
	end

	logic [0:0][63:0] m4_p;
	logic [79:0]      m4_side;

	bpc_mul #(.LANES(1), .SW(80)) u_mul_d (
		.clk(clk), .en(en),
		.a(num_s12), .b(PRESS_SCALE),
		.side_in({t10_s12, den_s12}),
		.p(m4_p), .side_out(m4_side)
	);

	logic [63:0] quo;
	logic        dz;
	logic [15:0] div_side;

	bpc_div #(.SW(16)) u_div (
		.clk(clk), .en(en),
		.num(m4_p[0]), .den(m4_side[63:0]),
		.side_in(m4_side[79:64]),
		.quo(quo), .dz(dz), .side_out(div_side)
	);

	// q*q and p8*p
	logic [63:0]      qv;
	logic [1:0][63:0] m5_p;
	logic [80:0]      m5_side;

	assign qv = asr64(quo, 13);

	bpc_mul #(.LANES(2), .SW(81)) u_mul_e (
		.clk(clk), .en(en),
		.a({p8, qv}), .b({quo, qv}),
		.side_in({div_side, dz, quo}),
		.p(m5_p), .side_out(m5_side)
	);

	logic [0:0][63:0] m6_p;
	logic [144:0]     m6_side;

	bpc_mul #(.LANES(1), .SW(145)) u_mul_f (
		.clk(clk), .en(en),
		.a(m5_p[0]), .b(p9),
		.side_in({m5_side, m5_p[1]}),
		.p(m6_p), .side_out(m6_side)
	);

	logic [63:0] sum_s85, fin;
	logic        dz_s85;
	logic [15:0] t10_s85;

	assign fin = asr64(sum_s85, 8) + {p7[59:0], 4'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s85 <= m6_side[127:64] + asr64(m6_p[0], 25) + asr64(m6_side[63:0], 19);
			dz_s85  <= m6_side[128];
			t10_s85 <= m6_side[144:129];
			m_tdata <= {t10_s85, dz_s85 ? 32'd0 : fin[39:8]};
		end
	end

endmodule

FILE: rtl/core/bpc_checker.sv
// Port-level checker for the compensation top level, bound to it below.
// Depends on baro_pressure_temp_compensation_top ports only.
module bpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        cfg_ready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid after reset");

endmodule

bind baro_pressure_temp_compensation_top bpc_checker u_bpc_checker (.*);
